// File: sv/icmper_pkg.sv
package icmper_pkg;

	localparam int MAX_FRAME_BYTES = 2048;
	localparam int CNT_W = $clog2(MAX_FRAME_BYTES + 1);
	localparam int REPLY_BYTES = 42;
	localparam int IDX_W = $clog2(REPLY_BYTES);
	localparam int DQ_DEPTH = 2;

	localparam logic [15:0] ETH_IPV4 = 16'h0800;
	localparam logic [7:0] IP_VER_IHL = 8'h45;
	localparam logic [7:0] IP_TTL = 8'd64;
	localparam logic [7:0] IP_PROTO_ICMP = 8'd1;
	localparam logic [7:0] IP_TOT_LEN = 8'd28;
	localparam logic [7:0] ICMP_ECHO_REQ = 8'd8;
	localparam logic [7:0] ICMP_PARAM_PROB = 8'd12;
	localparam logic [3:0] IHL_MIN = 4'd5;

	typedef enum logic [0:0] {
		CFG_LOCAL_IP = 1'b0,
		CFG_FAULT_MODE = 1'b1
	} cfg_idx_t;

	typedef enum logic [2:0] {
		FM_ECHO = 3'd0,
		FM_HOST = 3'd1,
		FM_NET = 3'd2,
		FM_TTL = 3'd3,
		FM_PROTO = 3'd4,
		FM_PORT = 3'd5,
		FM_FRAG = 3'd6,
		FM_PROHIB = 3'd7
	} fault_t;

	typedef struct packed {
		logic [7:0] rx_byte;
		logic rx_last;
	} rx_t;

	typedef struct packed {
		logic [7:0] tx_byte;
		logic tx_last;
	} tx_t;

	typedef struct packed {
		logic [47:0] peer_mac;
		logic [47:0] own_mac;
		logic [15:0] ip_ident;
		logic [31:0] peer_ip;
		logic [31:0] target_ip;
		logic [7:0] icmp_type;
		logic [7:0] icmp_code;
		logic [31:0] id_seq;
	} desc_t;

	function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] w);
		logic [16:0] s;
		s = {1'b0, a} + {1'b0, w};
		return s[15:0] + {15'd0, s[16]};
	endfunction

	function automatic logic [7:0] fault_type(input fault_t m);
		unique case (m)
			FM_ECHO: return 8'd0;
			FM_TTL: return 8'd11;
			default: return 8'd3;
		endcase
	endfunction

	function automatic logic [7:0] fault_code(input fault_t m);
		unique case (m)
			FM_HOST: return 8'd1;
			FM_PROTO: return 8'd2;
			FM_PORT: return 8'd3;
			FM_FRAG: return 8'd4;
			FM_PROHIB: return 8'd13;
			default: return 8'd0;
		endcase
	endfunction

endpackage

// File: sv/icmp_echo_responder_fault_inject_top.sv
// channel | handshake          | payload
// rx      | push / full        | rx.rx_byte, rx.rx_last
// tx      | pop / empty        | tx.tx_byte, tx.tx_last
// cfg     | cfg_valid/cfg_ready| cfg_index, cfg_data
// One byte per cycle unless full; a qualifying frame queues a request at its last byte.
// The request is queued; its first reply byte then goes through the output register.
// Each reply streams 42 bytes, one per cycle while pop keeps the output register drained.
// Up to two requests wait between parser and emitter; full rises only when both wait.
// Asynchronous active-low reset clears all control state; no clearing pass.
module icmp_echo_responder_fault_inject_top import icmper_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic push,
	output logic full,
	input rx_t rx,
	output logic empty,
	input logic pop,
	output tx_t tx,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [0:0] cfg_index,
	input logic [31:0] cfg_data
);

	logic accept, dpush, qv, done;
	desc_t dw, dr;

	assign cfg_ready = 1'b1;
	assign accept = push && !full;

	icmper_front u_front (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.accept(accept), .rx(rx), .desc_push(dpush), .desc(dw)
	);

	icmper_dq u_dq (
		.clk(clk), .arst_n(arst_n),
		.wr(dpush), .wdata(dw), .rd(done),
		.full(full), .nonempty(qv), .rdata(dr)
	);

	icmper_back u_back (
		.clk(clk), .arst_n(arst_n),
		.qv(qv), .d(dr), .done(done),
		.pop(pop), .empty(empty), .tx(tx)
	);

endmodule

// File: sv/icmper_front.sv
module icmper_front import icmper_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic cfg_valid,
	input logic [0:0] cfg_index,
	input logic [31:0] cfg_data,
	input logic accept,
	input rx_t rx,
	output logic desc_push,
	output desc_t desc
);

	logic [31:0] local_ip_q;
	fault_t fault_q;
	logic [CNT_W-1:0] cnt_q;
	logic [47:0] own_q, peer_q;
	logic [15:0] type_q, ident_q, sum_q;
	logic [3:0] hw_q;
	logic [7:0] proto_q;
	logic [31:0] pip_q, tip_q;
	logic [63:0] icmp_q;

	logic [7:0] b;
	logic [CNT_W-1:0] pos, off, off_n, k;
	logic [47:0] n_own, n_peer;
	logic [15:0] n_type, n_ident, n_sum, sum_base;
	logic [3:0] n_hw;
	logic [7:0] n_proto;
	logic [31:0] n_pip, n_tip;
	logic [63:0] n_icmp, icmp_base;
	logic win, qualify, bad;

	always_comb begin
		b = rx.rx_byte;
		pos = cnt_q;
		n_own = (pos < CNT_W'(6)) ? {own_q[39:0], b} : own_q;
		n_peer = (pos >= CNT_W'(6) && pos < CNT_W'(12)) ? {peer_q[39:0], b} : peer_q;
		n_type = (pos >= CNT_W'(12) && pos < CNT_W'(14)) ? {type_q[7:0], b} : type_q;
		n_hw = (pos == CNT_W'(14)) ? b[3:0] : hw_q;
		n_ident = (pos == CNT_W'(18) || pos == CNT_W'(19)) ? {ident_q[7:0], b} : ident_q;
		n_proto = (pos == CNT_W'(23)) ? b : proto_q;
		n_pip = (pos >= CNT_W'(26) && pos < CNT_W'(30)) ? {pip_q[23:0], b} : pip_q;
		n_tip = (pos >= CNT_W'(30) && pos < CNT_W'(34)) ? {tip_q[23:0], b} : tip_q;
		off = CNT_W'(14) + CNT_W'({hw_q, 2'b00});
		k = pos - off;
		win = pos > CNT_W'(14) && hw_q >= IHL_MIN && pos >= off && pos < off + CNT_W'(8);
		icmp_base = (pos == '0) ? 64'd0 : icmp_q;
		sum_base = (pos == '0) ? 16'd0 : sum_q;
		n_icmp = win ? {icmp_base[55:0], b} : icmp_base;
		n_sum = (win && (k[2:0] == 3'd1 || k[2:0] == 3'd5 || k[2:0] == 3'd7)) ?
			oc_add(sum_base, {icmp_base[7:0], b}) : sum_base;
		off_n = CNT_W'(14) + CNT_W'({n_hw, 2'b00});
		qualify = rx.rx_last && n_hw >= IHL_MIN && pos + CNT_W'(1) >= off_n + CNT_W'(8) &&
			n_type == ETH_IPV4 && n_proto == IP_PROTO_ICMP && n_tip == local_ip_q &&
			n_icmp[63:56] == ICMP_ECHO_REQ;
		bad = (~n_sum) != n_icmp[47:32];
		desc_push = accept && qualify;
		desc.peer_mac = n_peer;
		desc.own_mac = n_own;
		desc.ip_ident = n_ident;
		desc.peer_ip = n_pip;
		desc.target_ip = n_tip;
		desc.icmp_type = bad ? ICMP_PARAM_PROB : fault_type(fault_q);
		desc.icmp_code = bad ? 8'd0 : fault_code(fault_q);
		desc.id_seq = (!bad && fault_q == FM_ECHO) ? n_icmp[31:0] : 32'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			local_ip_q <= '0;
			fault_q <= FM_ECHO;
			cnt_q <= '0;
			own_q <= '0;
			peer_q <= '0;
			type_q <= '0;
			hw_q <= '0;
			ident_q <= '0;
			proto_q <= '0;
			pip_q <= '0;
			tip_q <= '0;
			icmp_q <= '0;
			sum_q <= '0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_idx_t'(cfg_index))
					CFG_LOCAL_IP: local_ip_q <= cfg_data;
					CFG_FAULT_MODE: fault_q <= fault_t'(cfg_data[2:0]);
				endcase
			end
			if (accept) begin
				own_q <= n_own;
				peer_q <= n_peer;
				type_q <= n_type;
				hw_q <= n_hw;
				ident_q <= n_ident;
				proto_q <= n_proto;
				pip_q <= n_pip;
				tip_q <= n_tip;
				icmp_q <= n_icmp;
				sum_q <= n_sum;
				if (rx.rx_last)
					cnt_q <= '0;
				else if (cnt_q < CNT_W'(MAX_FRAME_BYTES))
					cnt_q <= cnt_q + CNT_W'(1);
			end
		end
	end

endmodule

// File: sv/icmper_dq.sv
module icmper_dq import icmper_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic wr,
	input desc_t wdata,
	input logic rd,
	output logic full,
	output logic nonempty,
	output desc_t rdata
);

	localparam int PW = $clog2(DQ_DEPTH);

	desc_t mem_q [DQ_DEPTH];
	logic [PW-1:0] wp_q, rp_q;
	logic [PW:0] cnt_q;

	assign full = cnt_q == (PW+1)'(DQ_DEPTH);
	assign nonempty = cnt_q != '0;
	assign rdata = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) wp_q <= wp_q + PW'(1);
			if (rd) rp_q <= rp_q + PW'(1);
			cnt_q <= cnt_q + (PW+1)'(wr) - (PW+1)'(rd);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (PW+1)'(DQ_DEPTH)) else $error("queue count overflow");
	a_no_wr_full: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !wr) else $error("write while full");
	a_no_rd_empty: assert property (@(posedge clk) disable iff (!arst_n)
		rd |-> nonempty) else $error("read while empty");

endmodule

// File: sv/icmper_back.sv
module icmper_back import icmper_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic qv,
	input desc_t d,
	output logic done,
	input logic pop,
	output logic empty,
	output tx_t tx
);

	logic [IDX_W-1:0] idx_q;
	logic [15:0] ipsum_q, icsum_q;
	logic out_valid_q;
	tx_t out_q;
	logic adv, is_last;
	logic [15:0] ipw, icw, ipck, icck;
	logic [7:0] byt;

	assign adv = qv && (!out_valid_q || pop);
	assign is_last = idx_q == IDX_W'(REPLY_BYTES - 1);
	assign done = adv && is_last;
	assign empty = !out_valid_q;
	assign tx = out_q;
	assign ipck = ~ipsum_q;
	assign icck = ~icsum_q;

	always_comb begin
		unique case (idx_q)
			IDX_W'(0): ipw = {IP_VER_IHL, 8'd0};
			IDX_W'(1): ipw = {8'd0, IP_TOT_LEN};
			IDX_W'(2): ipw = d.ip_ident;
			IDX_W'(4): ipw = {IP_TTL, IP_PROTO_ICMP};
			IDX_W'(6): ipw = d.target_ip[31:16];
			IDX_W'(7): ipw = d.target_ip[15:0];
			IDX_W'(8): ipw = d.peer_ip[31:16];
			IDX_W'(9): ipw = d.peer_ip[15:0];
			default: ipw = 16'd0;
		endcase
		unique case (idx_q)
			IDX_W'(0): icw = {d.icmp_type, d.icmp_code};
			IDX_W'(2): icw = d.id_seq[31:16];
			IDX_W'(3): icw = d.id_seq[15:0];
			default: icw = 16'd0;
		endcase
		unique case (idx_q)
			IDX_W'(0): byt = d.peer_mac[47:40];
			IDX_W'(1): byt = d.peer_mac[39:32];
			IDX_W'(2): byt = d.peer_mac[31:24];
			IDX_W'(3): byt = d.peer_mac[23:16];
			IDX_W'(4): byt = d.peer_mac[15:8];
			IDX_W'(5): byt = d.peer_mac[7:0];
			IDX_W'(6): byt = d.own_mac[47:40];
			IDX_W'(7): byt = d.own_mac[39:32];
			IDX_W'(8): byt = d.own_mac[31:24];
			IDX_W'(9): byt = d.own_mac[23:16];
			IDX_W'(10): byt = d.own_mac[15:8];
			IDX_W'(11): byt = d.own_mac[7:0];
			IDX_W'(12): byt = ETH_IPV4[15:8];
			IDX_W'(13): byt = ETH_IPV4[7:0];
			IDX_W'(14): byt = IP_VER_IHL;
			IDX_W'(17): byt = IP_TOT_LEN;
			IDX_W'(18): byt = d.ip_ident[15:8];
			IDX_W'(19): byt = d.ip_ident[7:0];
			IDX_W'(22): byt = IP_TTL;
			IDX_W'(23): byt = IP_PROTO_ICMP;
			IDX_W'(24): byt = ipck[15:8];
			IDX_W'(25): byt = ipck[7:0];
			IDX_W'(26): byt = d.target_ip[31:24];
			IDX_W'(27): byt = d.target_ip[23:16];
			IDX_W'(28): byt = d.target_ip[15:8];
			IDX_W'(29): byt = d.target_ip[7:0];
			IDX_W'(30): byt = d.peer_ip[31:24];
			IDX_W'(31): byt = d.peer_ip[23:16];
			IDX_W'(32): byt = d.peer_ip[15:8];
			IDX_W'(33): byt = d.peer_ip[7:0];
			IDX_W'(34): byt = d.icmp_type;
			IDX_W'(35): byt = d.icmp_code;
			IDX_W'(36): byt = icck[15:8];
			IDX_W'(37): byt = icck[7:0];
			IDX_W'(38): byt = d.id_seq[31:24];
			IDX_W'(39): byt = d.id_seq[23:16];
			IDX_W'(40): byt = d.id_seq[15:8];
			IDX_W'(41): byt = d.id_seq[7:0];
			default: byt = 8'd0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_q.tx_byte <= byt;
			out_q.tx_last <= is_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			ipsum_q <= '0;
			icsum_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				out_valid_q <= 1'b1;
				if (is_last) begin
					idx_q <= '0;
					ipsum_q <= '0;
					icsum_q <= '0;
				end else begin
					idx_q <= idx_q + IDX_W'(1);
					ipsum_q <= oc_add(ipsum_q, ipw);
					icsum_q <= oc_add(icsum_q, icw);
				end
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> idx_q == '0) else $error("index did not wrap");
	a_mid_reply: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q != '0 |-> qv) else $error("reply in progress without request");
	a_last_flag: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> out_q.tx_last == $past(is_last)) else $error("last flag mismatch");

endmodule
